// ===== src/blit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_pkg
// Shared widths, opcodes, register indexes and the rectangle clip function
// of the blitter command front end.
// ----------------------------------------------------------------------------
package blit_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int DIM_W     = 13;
   localparam int PITCH_W   = 15;
   localparam int BPP_W     = 3;
   localparam int COORD_W   = 16;
   localparam int CALC_W    = 20;
   localparam int OFFS_W    = 26;
   localparam int ROW_W     = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_PITCH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_PITCH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BPP        = 3'd6;

   localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

   typedef enum logic [1:0] {
      OP_BLIT   = 2'd0,
      OP_FILL   = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef logic signed [CALC_W-1:0] calc_type;

   // Origin, size and the opposite origin that absorbs the left/top cut.
   typedef struct packed {
      calc_type x;
      calc_type y;
      calc_type w;
      calc_type h;
      calc_type ox;
      calc_type oy;
   } rect_type;

   function automatic calc_type dim(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? calc_type'(MAX_DIM) : calc_type'(v);
   endfunction

   // Note that a rectangle starting beyond the surface ends with a negative
   // size; callers treat any size at or below zero as empty.
   function automatic rect_type clip_rect(input rect_type r, input calc_type sw,
                                          input calc_type sh);
      rect_type c;
      c = r;
      if (c.x < 0) begin
         c.w  = c.w + c.x;
         c.ox = c.ox - c.x;
         c.x  = '0;
      end
      if (c.y < 0) begin
         c.h  = c.h + c.y;
         c.oy = c.oy - c.y;
         c.y  = '0;
      end
      if (c.x >= sw || c.y >= sh || c.w <= 0 || c.h <= 0) begin
         c.w = '0;
         c.h = '0;
      end
      if (c.x + c.w > sw) c.w = sw - c.x;
      if (c.y + c.h > sh) c.h = sh - c.y;
      return c;
   endfunction

endpackage

// ===== src/blit_fill_rect_clip_address_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_fill_rect_clip_address_unit
// Clips blit, fill and update rectangles against the surfaces and computes
// the first-row byte offsets and the row length.
// ----------------------------------------------------------------------------
// A result passes the command, clip and offset registers in order before it
// can transfer. Throughput: one command per cycle while the result side
// does not stall; the offset stage holds the only multipliers, the clip
// stage the compare and add chain.
// Reset clears all stage valid bits and loads the surface registers with
// zero and bytes_per_pixel with 4.
module blit_fill_rect_clip_address_unit
   import blit_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_data,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic                        req_use_src_rect,
   input  logic signed [COORD_W-1:0]   req_src_x,
   input  logic signed [COORD_W-1:0]   req_src_y,
   input  logic signed [COORD_W-1:0]   req_src_w,
   input  logic signed [COORD_W-1:0]   req_src_h,
   input  logic                        req_use_dst_rect,
   input  logic signed [COORD_W-1:0]   req_dst_x,
   input  logic signed [COORD_W-1:0]   req_dst_y,
   input  logic signed [COORD_W-1:0]   req_dst_w,
   input  logic signed [COORD_W-1:0]   req_dst_h,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_empty_res,
   output logic [DIM_W-1:0]            rsp_out_src_x,
   output logic [DIM_W-1:0]            rsp_out_src_y,
   output logic [DIM_W-1:0]            rsp_out_dst_x,
   output logic [DIM_W-1:0]            rsp_out_dst_y,
   output logic [DIM_W-1:0]            rsp_out_width,
   output logic [DIM_W-1:0]            rsp_out_height,
   output logic [OFFS_W-1:0]           rsp_src_offset,
   output logic [OFFS_W-1:0]           rsp_dst_offset,
   output logic [ROW_W-1:0]            rsp_row_len
);

   // Configuration registers
   logic [DIM_W-1:0]   src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [PITCH_W-1:0] src_pitch_ff, dst_pitch_ff;
   logic [BPP_W-1:0]   bpp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= '0;
         src_height_ff <= '0;
         src_pitch_ff  <= '0;
         dst_width_ff  <= '0;
         dst_height_ff <= '0;
         dst_pitch_ff  <= '0;
         bpp_ff        <= BPP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_data[DIM_W-1:0];
            CSR_SRC_PITCH:  src_pitch_ff  <= csr_data[PITCH_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data[DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_data[DIM_W-1:0];
            CSR_DST_PITCH:  dst_pitch_ff  <= csr_data[PITCH_W-1:0];
            CSR_BPP:        bpp_ff        <= csr_data[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline enables: a stage moves when it is empty or the next one moves.
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_en, s2_en, s3_en;

   assign s3_en     = !rsp_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;

   // Stage 1: command register
   logic [1:0]                op_ff;
   logic                      use_src_ff, use_dst_ff;
   logic signed [COORD_W-1:0] sx_ff, sy_ff, sw_ff, sh_ff;
   logic signed [COORD_W-1:0] dx_ff, dy_ff, dw_ff, dh_ff;
   logic                      s1_valid_in;

   assign s1_valid_in = s1_en ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_en && req_valid) begin
         op_ff      <= req_opcode;
         use_src_ff <= req_use_src_rect;
         use_dst_ff <= req_use_dst_rect;
         sx_ff      <= req_src_x;
         sy_ff      <= req_src_y;
         sw_ff      <= req_src_w;
         sh_ff      <= req_src_h;
         dx_ff      <= req_dst_x;
         dy_ff      <= req_dst_y;
         dw_ff      <= req_dst_w;
         dh_ff      <= req_dst_h;
      end
   end

   // Stage 2: clipping
   calc_type   src_w_dim, src_h_dim, dst_w_dim, dst_h_dim;
   calc_type   upd_x, upd_y, upd_w, upd_h;
   rect_type   blit_in, blit_src, blit_swap, final_rect;
   logic       is_blit, clip_empty;
   logic       s2_valid_in, s2_empty_in;
   logic [DIM_W-1:0] s2_sx_in, s2_sy_in, s2_dx_in, s2_dy_in, s2_w_in, s2_h_in;
   logic       s2_empty_ff;
   logic [DIM_W-1:0] s2_sx_ff, s2_sy_ff, s2_dx_ff, s2_dy_ff, s2_w_ff, s2_h_ff;

   assign src_w_dim = dim(src_width_ff);
   assign src_h_dim = dim(src_height_ff);
   assign dst_w_dim = dim(dst_width_ff);
   assign dst_h_dim = dim(dst_height_ff);

   always_comb begin
      blit_in = '{x:  use_src_ff ? calc_type'(sx_ff) : calc_type'(0),
                  y:  use_src_ff ? calc_type'(sy_ff) : calc_type'(0),
                  w:  use_src_ff ? calc_type'(sw_ff) : src_w_dim,
                  h:  use_src_ff ? calc_type'(sh_ff) : src_h_dim,
                  ox: use_dst_ff ? calc_type'(dx_ff) : calc_type'(0),
                  oy: use_dst_ff ? calc_type'(dy_ff) : calc_type'(0)};
      blit_src  = clip_rect(blit_in, src_w_dim, src_h_dim);
      // The destination clip works on the destination origin and moves its
      // cut onto the source origin.
      blit_swap = '{x: blit_src.ox, y: blit_src.oy, w: blit_src.w, h: blit_src.h,
                    ox: blit_src.x, oy: blit_src.y};

      // Update: the left/top cut comes first, then a zero size runs to the edge.
      upd_x = calc_type'(dx_ff);
      upd_y = calc_type'(dy_ff);
      upd_w = calc_type'(dw_ff);
      upd_h = calc_type'(dh_ff);
      if (upd_x < 0) begin
         upd_w = upd_w + upd_x;
         upd_x = '0;
      end
      if (upd_y < 0) begin
         upd_h = upd_h + upd_y;
         upd_y = '0;
      end
      if (upd_w == 0) upd_w = dst_w_dim - upd_x;
      if (upd_h == 0) upd_h = dst_h_dim - upd_y;

      is_blit    = 1'b0;
      clip_empty = 1'b0;
      final_rect = '0;
      case (opcode_type'(op_ff))
         OP_BLIT: begin
            is_blit    = 1'b1;
            final_rect = clip_rect(blit_swap, dst_w_dim, dst_h_dim);
         end
         OP_FILL: begin
            if (use_dst_ff) begin
               final_rect = clip_rect('{x: calc_type'(dx_ff), y: calc_type'(dy_ff),
                                        w: calc_type'(dw_ff), h: calc_type'(dh_ff),
                                        ox: '0, oy: '0}, dst_w_dim, dst_h_dim);
            end else begin
               final_rect = clip_rect('{x: '0, y: '0, w: dst_w_dim, h: dst_h_dim,
                                        ox: '0, oy: '0}, dst_w_dim, dst_h_dim);
            end
         end
         OP_UPDATE: begin
            final_rect = clip_rect('{x: upd_x, y: upd_y, w: upd_w, h: upd_h,
                                     ox: '0, oy: '0}, dst_w_dim, dst_h_dim);
         end
         default: begin
            clip_empty = 1'b1;
         end
      endcase

      if (final_rect.w <= 0 || final_rect.h <= 0) clip_empty = 1'b1;

      s2_empty_in = clip_empty;
      if (clip_empty) begin
         s2_sx_in = '0;
         s2_sy_in = '0;
         s2_dx_in = '0;
         s2_dy_in = '0;
         s2_w_in  = '0;
         s2_h_in  = '0;
      end else begin
         s2_sx_in = is_blit ? final_rect.ox[DIM_W-1:0] : '0;
         s2_sy_in = is_blit ? final_rect.oy[DIM_W-1:0] : '0;
         s2_dx_in = final_rect.x[DIM_W-1:0];
         s2_dy_in = final_rect.y[DIM_W-1:0];
         s2_w_in  = final_rect.w[DIM_W-1:0];
         s2_h_in  = final_rect.h[DIM_W-1:0];
      end
   end

   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s2_en && s1_valid_ff) begin
         s2_empty_ff <= s2_empty_in;
         s2_sx_ff    <= s2_sx_in;
         s2_sy_ff    <= s2_sy_in;
         s2_dx_ff    <= s2_dx_in;
         s2_dy_ff    <= s2_dy_in;
         s2_w_ff     <= s2_w_in;
         s2_h_ff     <= s2_h_in;
      end
   end

   // Stage 3: byte offsets. Empty results carry zero coordinates and non-blit
   // results zero source coordinates, so those offsets come out as zero by themselves.
   logic [DIM_W+PITCH_W-1:0] src_row_prod, dst_row_prod;
   logic [DIM_W+BPP_W-1:0]   src_col_prod, dst_col_prod, row_prod;
   logic                     rsp_valid_in;
   logic [OFFS_W-1:0]        src_offset_in, dst_offset_in;
   logic [ROW_W-1:0]         row_len_in;

   logic                     empty_ff;
   logic [DIM_W-1:0]         out_sx_ff, out_sy_ff, out_dx_ff, out_dy_ff;
   logic [DIM_W-1:0]         out_w_ff, out_h_ff;
   logic [OFFS_W-1:0]        src_offset_ff, dst_offset_ff;
   logic [ROW_W-1:0]         row_len_ff;

   assign src_row_prod  = s2_sy_ff * src_pitch_ff;
   assign dst_row_prod  = s2_dy_ff * dst_pitch_ff;
   assign src_col_prod  = s2_sx_ff * bpp_ff;
   assign dst_col_prod  = s2_dx_ff * bpp_ff;
   assign row_prod      = s2_w_ff * bpp_ff;
   assign src_offset_in = OFFS_W'(src_row_prod) + OFFS_W'(src_col_prod);
   assign dst_offset_in = OFFS_W'(dst_row_prod) + OFFS_W'(dst_col_prod);
   assign row_len_in    = ROW_W'(row_prod);
   assign rsp_valid_in  = s3_en ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s3_en && s2_valid_ff) begin
         empty_ff      <= s2_empty_ff;
         out_sx_ff     <= s2_sx_ff;
         out_sy_ff     <= s2_sy_ff;
         out_dx_ff     <= s2_dx_ff;
         out_dy_ff     <= s2_dy_ff;
         out_w_ff      <= s2_w_ff;
         out_h_ff      <= s2_h_ff;
         src_offset_ff <= src_offset_in;
         dst_offset_ff <= dst_offset_in;
         row_len_ff    <= row_len_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_empty_res  = empty_ff;
   assign rsp_out_src_x  = out_sx_ff;
   assign rsp_out_src_y  = out_sy_ff;
   assign rsp_out_dst_x  = out_dx_ff;
   assign rsp_out_dst_y  = out_dy_ff;
   assign rsp_out_width  = out_w_ff;
   assign rsp_out_height = out_h_ff;
   assign rsp_src_offset = src_offset_ff;
   assign rsp_dst_offset = dst_offset_ff;
   assign rsp_row_len    = row_len_ff;

endmodule

// ===== bench/blit_clip_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_clip_checker
// Watches the register, command and result channels of the clip and address
// unit. It keeps its own copy of the surface registers, computes the
// clipped rectangle and offsets for every command transfer and compares each
// result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module blit_clip_checker
   import blit_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DAT_W-1:0]      csr_data,

   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic                      req_use_src_rect,
   input  logic signed [COORD_W-1:0] req_src_x,
   input  logic signed [COORD_W-1:0] req_src_y,
   input  logic signed [COORD_W-1:0] req_src_w,
   input  logic signed [COORD_W-1:0] req_src_h,
   input  logic                      req_use_dst_rect,
   input  logic signed [COORD_W-1:0] req_dst_x,
   input  logic signed [COORD_W-1:0] req_dst_y,
   input  logic signed [COORD_W-1:0] req_dst_w,
   input  logic signed [COORD_W-1:0] req_dst_h,

   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_empty_res,
   input  logic [DIM_W-1:0]          rsp_out_src_x,
   input  logic [DIM_W-1:0]          rsp_out_src_y,
   input  logic [DIM_W-1:0]          rsp_out_dst_x,
   input  logic [DIM_W-1:0]          rsp_out_dst_y,
   input  logic [DIM_W-1:0]          rsp_out_width,
   input  logic [DIM_W-1:0]          rsp_out_height,
   input  logic [OFFS_W-1:0]         rsp_src_offset,
   input  logic [OFFS_W-1:0]         rsp_dst_offset,
   input  logic [ROW_W-1:0]          rsp_row_len,

   output int                        fail_count,
   output int                        pending_count
);

   typedef struct packed {
      logic              is_empty;
      logic [DIM_W-1:0]  src_x;
      logic [DIM_W-1:0]  src_y;
      logic [DIM_W-1:0]  dst_x;
      logic [DIM_W-1:0]  dst_y;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [OFFS_W-1:0] src_offset;
      logic [OFFS_W-1:0] dst_offset;
      logic [ROW_W-1:0]  row_len;
   } clipped_rect_type;

   logic [DIM_W-1:0]   cfg_src_width;
   logic [DIM_W-1:0]   cfg_src_height;
   logic [PITCH_W-1:0] cfg_src_pitch;
   logic [DIM_W-1:0]   cfg_dst_width;
   logic [DIM_W-1:0]   cfg_dst_height;
   logic [PITCH_W-1:0] cfg_dst_pitch;
   logic [BPP_W-1:0]   cfg_bpp;

   clipped_rect_type expected_rects[$];
   clipped_rect_type oldest;
   int               fails = 0;

   function automatic longint clamp_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
   endfunction

   // Whatever is cut off the left or top edge moves onto the opposite origin.
   function automatic void clip_to_surface(inout longint x, inout longint y,
                                           inout longint w, inout longint h,
                                           inout longint ox, inout longint oy,
                                           input longint sw, input longint sh);
      if (x < 0) begin
         w  = w + x;
         ox = ox - x;
         x  = 0;
      end
      if (y < 0) begin
         h  = h + y;
         oy = oy - y;
         y  = 0;
      end
      if (x >= sw || y >= sh || w <= 0 || h <= 0) begin
         w = 0;
         h = 0;
      end
      if (x + w > sw) w = sw - x;
      if (y + h > sh) h = sh - y;
   endfunction

   function automatic clipped_rect_type clip_command(
      input logic [1:0] op, input logic use_src, input logic use_dst,
      input logic signed [COORD_W-1:0] isx, input logic signed [COORD_W-1:0] isy,
      input logic signed [COORD_W-1:0] isw, input logic signed [COORD_W-1:0] ish,
      input logic signed [COORD_W-1:0] idx, input logic signed [COORD_W-1:0] idy,
      input logic signed [COORD_W-1:0] idw, input logic signed [COORD_W-1:0] idh);
      longint           sx, sy, dx, dy, w, h, sink_x, sink_y, dw, dh, bpp, soff, doff, row;
      clipped_rect_type r;
      sx     = 0;
      sy     = 0;
      dx     = 0;
      dy     = 0;
      w      = 0;
      h      = 0;
      sink_x = 0;
      sink_y = 0;
      dw     = clamp_dim(cfg_dst_width);
      dh     = clamp_dim(cfg_dst_height);
      if (op == OP_BLIT) begin
         if (use_src) begin
            sx = longint'(isx);
            sy = longint'(isy);
            w  = longint'(isw);
            h  = longint'(ish);
         end else begin
            w = clamp_dim(cfg_src_width);
            h = clamp_dim(cfg_src_height);
         end
         if (use_dst) begin
            dx = longint'(idx);
            dy = longint'(idy);
         end
         clip_to_surface(sx, sy, w, h, dx, dy, clamp_dim(cfg_src_width),
                         clamp_dim(cfg_src_height));
         clip_to_surface(dx, dy, w, h, sx, sy, dw, dh);
      end else if (op == OP_FILL) begin
         if (use_dst) begin
            dx = longint'(idx);
            dy = longint'(idy);
            w  = longint'(idw);
            h  = longint'(idh);
         end else begin
            w = dw;
            h = dh;
         end
         clip_to_surface(dx, dy, w, h, sink_x, sink_y, dw, dh);
      end else if (op == OP_UPDATE) begin
         dx = longint'(idx);
         dy = longint'(idy);
         w  = longint'(idw);
         h  = longint'(idh);
         if (dx < 0) begin
            w  = w + dx;
            dx = 0;
         end
         if (dy < 0) begin
            h  = h + dy;
            dy = 0;
         end
         // A zero size left after the edge cut reaches to the surface edge.
         if (w == 0) w = dw - dx;
         if (h == 0) h = dh - dy;
         clip_to_surface(dx, dy, w, h, sink_x, sink_y, dw, dh);
      end

      r = '0;
      if (op == OP_NONE || w <= 0 || h <= 0) begin
         r.is_empty = 1'b1;
         return r;
      end
      if (op != OP_BLIT) begin
         sx = 0;
         sy = 0;
      end
      bpp  = longint'(cfg_bpp);
      soff = sy * longint'(cfg_src_pitch) + sx * bpp;
      doff = dy * longint'(cfg_dst_pitch) + dx * bpp;
      row  = w * bpp;
      r.src_x      = sx[DIM_W-1:0];
      r.src_y      = sy[DIM_W-1:0];
      r.dst_x      = dx[DIM_W-1:0];
      r.dst_y      = dy[DIM_W-1:0];
      r.width      = w[DIM_W-1:0];
      r.height     = h[DIM_W-1:0];
      r.src_offset = soff[OFFS_W-1:0];
      r.dst_offset = doff[OFFS_W-1:0];
      r.row_len    = row[ROW_W-1:0];
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [OFFS_W-1:0] want,
                                input logic [OFFS_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_src_width  = '0;
         cfg_src_height = '0;
         cfg_src_pitch  = '0;
         cfg_dst_width  = '0;
         cfg_dst_height = '0;
         cfg_dst_pitch  = '0;
         cfg_bpp        = BPP_RESET;
         expected_rects.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rects.size() == 0) begin
               $display("%0t ns: result transfer with no command outstanding", $time);
               fails++;
            end else begin
               oldest = expected_rects.pop_front();
               compare_field("empty_res", OFFS_W'(oldest.is_empty), OFFS_W'(rsp_empty_res));
               compare_field("out_src_x", OFFS_W'(oldest.src_x), OFFS_W'(rsp_out_src_x));
               compare_field("out_src_y", OFFS_W'(oldest.src_y), OFFS_W'(rsp_out_src_y));
               compare_field("out_dst_x", OFFS_W'(oldest.dst_x), OFFS_W'(rsp_out_dst_x));
               compare_field("out_dst_y", OFFS_W'(oldest.dst_y), OFFS_W'(rsp_out_dst_y));
               compare_field("out_width", OFFS_W'(oldest.width), OFFS_W'(rsp_out_width));
               compare_field("out_height", OFFS_W'(oldest.height),
                             OFFS_W'(rsp_out_height));
               compare_field("src_offset", oldest.src_offset, rsp_src_offset);
               compare_field("dst_offset", oldest.dst_offset, rsp_dst_offset);
               compare_field("row_len", OFFS_W'(oldest.row_len), OFFS_W'(rsp_row_len));
            end
         end
         if (req_valid && !req_stall)
            expected_rects.push_back(clip_command(req_opcode, req_use_src_rect,
               req_use_dst_rect, req_src_x, req_src_y, req_src_w, req_src_h,
               req_dst_x, req_dst_y, req_dst_w, req_dst_h));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SRC_WIDTH:  cfg_src_width  = csr_data[DIM_W-1:0];
               CSR_SRC_HEIGHT: cfg_src_height = csr_data[DIM_W-1:0];
               CSR_SRC_PITCH:  cfg_src_pitch  = csr_data[PITCH_W-1:0];
               CSR_DST_WIDTH:  cfg_dst_width  = csr_data[DIM_W-1:0];
               CSR_DST_HEIGHT: cfg_dst_height = csr_data[DIM_W-1:0];
               CSR_DST_PITCH:  cfg_dst_pitch  = csr_data[PITCH_W-1:0];
               CSR_BPP:        cfg_bpp        = csr_data[BPP_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_rects.size();
      fail_count    <= fails;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the clip and address unit with directed and random blit, fill and
// update commands over a series of surface settings, with random gaps and
// stalls on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench
   import blit_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DAT_W-1:0]      csr_data = '0;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_opcode = '0;
   logic                      req_use_src_rect = 1'b0;
   logic signed [COORD_W-1:0] req_src_x = '0;
   logic signed [COORD_W-1:0] req_src_y = '0;
   logic signed [COORD_W-1:0] req_src_w = '0;
   logic signed [COORD_W-1:0] req_src_h = '0;
   logic                      req_use_dst_rect = 1'b0;
   logic signed [COORD_W-1:0] req_dst_x = '0;
   logic signed [COORD_W-1:0] req_dst_y = '0;
   logic signed [COORD_W-1:0] req_dst_w = '0;
   logic signed [COORD_W-1:0] req_dst_h = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_empty_res;
   logic [DIM_W-1:0]          rsp_out_src_x;
   logic [DIM_W-1:0]          rsp_out_src_y;
   logic [DIM_W-1:0]          rsp_out_dst_x;
   logic [DIM_W-1:0]          rsp_out_dst_y;
   logic [DIM_W-1:0]          rsp_out_width;
   logic [DIM_W-1:0]          rsp_out_height;
   logic [OFFS_W-1:0]         rsp_src_offset;
   logic [OFFS_W-1:0]         rsp_dst_offset;
   logic [ROW_W-1:0]          rsp_row_len;

   int                        fail_count;
   int                        pending_count;

   // Shared pacing controls between the command and result processes.
   logic                      no_idle = 1'b0;
   int                        hold_requests = 0;
   int                        holds_served = 0;

   // Coordinate spread for random commands, taken from the surface sizes.
   int                        span_sw = 0;
   int                        span_sh = 0;
   int                        span_dw = 0;
   int                        span_dh = 0;

   blit_fill_rect_clip_address_unit dut (.*);

   blit_clip_checker check_unit (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Result side: stall for a random number of cycles before each transfer,
   // or for a long stretch when one is requested.
   initial begin
      int gap;
      forever begin
         if (hold_requests != holds_served) begin
            holds_served++;
            gap = 60;
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic int gen_coord(input int span);
      int v;
      case ($urandom_range(0, 9))
         0: begin
            v = $urandom;
         end
         1: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: begin
            v = int'($urandom_range(0, 2 * span + 16)) - span - 8;
         end
      endcase
      return v;
   endfunction

   function automatic int pick_dim();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 200);
   endfunction

   // Field values are taken modulo their port widths.
   task automatic send_cmd(input opcode_type op, input int use_src,
                           input int sx, input int sy, input int sw, input int sh,
                           input int use_dst,
                           input int dx, input int dy, input int dw, input int dh);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_use_src_rect <= use_src[0];
      req_src_x        <= sx[COORD_W-1:0];
      req_src_y        <= sy[COORD_W-1:0];
      req_src_w        <= sw[COORD_W-1:0];
      req_src_h        <= sh[COORD_W-1:0];
      req_use_dst_rect <= use_dst[0];
      req_dst_x        <= dx[COORD_W-1:0];
      req_dst_y        <= dy[COORD_W-1:0];
      req_dst_w        <= dw[COORD_W-1:0];
      req_dst_h        <= dh[COORD_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DAT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Registers change only with the pipeline empty.
   task automatic set_surfaces(input int sw, input int sh, input int sp,
                               input int dw, input int dh, input int dp, input int bpp);
      wait_drained();
      repeat (5) @(negedge clock);
      csr_write(CSR_SRC_WIDTH, sw);
      csr_write(CSR_SRC_HEIGHT, sh);
      csr_write(CSR_SRC_PITCH, sp);
      csr_write(CSR_DST_WIDTH, dw);
      csr_write(CSR_DST_HEIGHT, dh);
      csr_write(CSR_DST_PITCH, dp);
      csr_write(CSR_BPP, bpp);
      span_sw = (sw > MAX_DIM) ? MAX_DIM : sw;
      span_sh = (sh > MAX_DIM) ? MAX_DIM : sh;
      span_dw = (dw > MAX_DIM) ? MAX_DIM : dw;
      span_dh = (dh > MAX_DIM) ? MAX_DIM : dh;
   endtask

   initial begin
      int         r;
      int         drain_wait;
      opcode_type op;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Surfaces are zero sized out of reset, so everything comes back empty.
      send_cmd(OP_BLIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      set_surfaces(64, 48, 256, 80, 60, 320, 4);
      send_cmd(OP_BLIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_BLIT, 1, 8, 4, 20, 10, 1, 10, 5, 0, 0);
      send_cmd(OP_BLIT, 1, -6, -3, 20, 10, 1, 10, 5, 0, 0);
      send_cmd(OP_BLIT, 1, 0, 0, 30, 30, 1, -7, -9, 0, 0);
      send_cmd(OP_BLIT, 1, 70, 0, 10, 10, 1, 0, 0, 0, 0);
      send_cmd(OP_BLIT, 1, 0, 0, 0, 5, 0, 0, 0, 0, 0);
      send_cmd(OP_BLIT, 1, 0, 0, -4, 5, 0, 0, 0, 0, 0);
      send_cmd(OP_BLIT, 1, 50, 40, 30, 30, 1, 70, 50, 0, 0);
      send_cmd(OP_BLIT, 1, -32768, -32768, 32767, 32767, 1, 32767, 32767, -1, -1);
      send_cmd(OP_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_FILL, 0, 0, 0, 0, 0, 1, 70, 55, 30, 30);
      send_cmd(OP_FILL, 1, 5, 5, 5, 5, 1, -10, -10, 20, 20);
      send_cmd(OP_FILL, 0, 0, 0, 0, 0, 1, 10, 10, 0, 4);
      send_cmd(OP_FILL, 0, 0, 0, 0, 0, 1, 80, 0, 5, 5);
      send_cmd(OP_UPDATE, 1, 3, 3, 3, 3, 1, 10, 10, 0, 0);
      send_cmd(OP_UPDATE, 0, 0, 0, 0, 0, 0, -5, 3, 5, 7);
      send_cmd(OP_UPDATE, 0, 0, 0, 0, 0, 0, 100, 0, 5, 5);
      send_cmd(OP_UPDATE, 0, 0, 0, 0, 0, 0, 32767, -32768, -32768, 32767);
      send_cmd(OP_NONE, 1, 1, 2, 3, 4, 1, 5, 6, 7, 8);

      // Oversized surfaces and an odd pixel size; offsets wrap.
      set_surfaces(8191, 4097, 32767, 4096, 4096, 32767, 3);
      send_cmd(OP_BLIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_UPDATE, 0, 0, 0, 0, 0, 0, 4095, 4095, 0, 0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_surfaces(4096, 4096, 16384, 4096, 4096, 16384, 4);
            1: set_surfaces(1, 1, 0, 1, 1, 32767, 1);
            2: set_surfaces(0, 0, 0, 3000, 2000, 12000, 4);
            3: begin
               set_surfaces(8191, 4097, 32767, 8191, 6000, 32767, 7);
               csr_write(CSR_UNUSED, $urandom);
            end
            default: begin
               set_surfaces(pick_dim(), pick_dim(), $urandom_range(0, 32767),
                            pick_dim(), pick_dim(), $urandom_range(0, 32767),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) :
                            ($urandom_range(0, 1) ? 1 : 4));
            end
         endcase
         no_idle = (phase == 1 || phase == 6);
         for (int n = 0; n < 80; n++) begin
            // The result side holds off while commands keep coming.
            if (phase == 5 && n == 10) begin
               hold_requests++;
               no_idle = 1'b1;
            end
            if (phase == 5 && n == 34) no_idle = 1'b0;
            if (n == 60) wait_drained();
            r  = $urandom_range(0, 9);
            op = (r < 4) ? OP_BLIT : (r < 7) ? OP_FILL : (r < 9) ? OP_UPDATE : OP_NONE;
            send_cmd(op, int'($urandom_range(0, 1)),
                     gen_coord(span_sw), gen_coord(span_sh),
                     gen_coord(span_sw), gen_coord(span_sh),
                     int'($urandom_range(0, 1)),
                     gen_coord(span_dw), gen_coord(span_dh),
                     gen_coord(span_dw), gen_coord(span_dh));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      drain_wait = 0;
      while (pending_count != 0 && drain_wait < 2000) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (8) @(negedge clock);
      if (pending_count != 0)
         $display("%0t ns: %0d results never arrived", $time, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
